[hdl/fsec_pkg.sv]
`timescale 1ns / 1ps

package fsec_pkg;

  // Input command codes.
  localparam logic [1:0] CMD_ENC     = 2'd0;
  localparam logic [1:0] CMD_BUTTON  = 2'd1;
  localparam logic [1:0] CMD_RPM     = 2'd2;

  // Register map, indexed by cfg_paddr[2].
  localparam logic REG_LONG_PRESS = 1'b0;

  localparam logic [23:0] LONG_PRESS_RST = 24'd2000000;

  // Setpoint limits and step sizes.
  localparam logic [6:0] SP_START = 7'd15;
  localparam logic [6:0] SP_MAX   = 7'd100;
  localparam logic [3:0] STEP_1   = 4'd1;
  localparam logic [3:0] STEP_2   = 4'd2;
  localparam logic [3:0] STEP_5   = 4'd5;
  localparam logic [3:0] STEP_10  = 4'd10;

  localparam logic [11:0] RPM_PER_PCT = 12'd21;

  // Duty is floor(x * 4096 / 13125), held to 0..65535, in both modes; x =
  // 2100 * setpoint in open loop, 2121 * setpoint - measured in closed loop.
  localparam logic [18:0] OPEN_GAIN   = 19'd2100;
  localparam logic [18:0] CLOSED_GAIN = 19'd2121;
  localparam logic [19:0] X_FULL      = 20'd210000;
  localparam logic [29:0] DIV_D       = 30'd13125;
  localparam logic [30:0] RECIP       = 31'((64'd1 << 44) / 64'd13125);

  typedef struct packed {
    logic [6:0]  setpoint;
    logic [3:0]  step;
    logic        loop_on;
    logic [13:0] measured;
    logic        kick;
  } snap_t;

endpackage

[hdl/fsec_ctrl.sv]
`timescale 1ns / 1ps

module fsec_ctrl import fsec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [1:0]  in_cmd,
  input  logic        in_enc_a,
  input  logic        in_enc_b,
  input  logic [23:0] in_held_us,
  input  logic [13:0] in_rpm_in,
  input  logic [23:0] long_press_us,
  output logic        snap_valid,
  output snap_t       snap
);

  logic        v1_r;
  logic [1:0]  cmd_r;
  logic        a_r;
  logic        b_r;
  logic [23:0] held_r;
  logic [13:0] rpm_r;

  logic        last_a_r, last_a_nxt;
  logic [6:0]  sp_r, sp_nxt;
  logic        running_r, running_nxt;
  logic [3:0]  step_r, step_nxt;
  logic        loop_r, loop_nxt;
  logic [13:0] meas_r, meas_nxt;
  logic        kick_nxt;

  logic        sv_r;
  snap_t       snap_r;

  logic signed [8:0] c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r  <= in_cmd;
      a_r    <= in_enc_a;
      b_r    <= in_enc_b;
      held_r <= in_held_us;
      rpm_r  <= in_rpm_in;
    end
  end

  always_comb begin
    last_a_nxt  = last_a_r;
    sp_nxt      = sp_r;
    running_nxt = running_r;
    step_nxt    = step_r;
    loop_nxt    = loop_r;
    meas_nxt    = meas_r;
    kick_nxt    = 1'b0;
    c           = $signed({2'b00, sp_r});
    case (cmd_r)
      CMD_ENC: begin
        if (a_r != last_a_r) begin
          if (b_r != a_r) begin
            c = $signed({2'b00, sp_r}) + $signed({5'b00000, step_r});
          end else begin
            c = $signed({2'b00, sp_r}) - $signed({5'b00000, step_r});
          end
          if (c > 9'sd0 && !running_r) begin
            c           = $signed({2'b00, SP_START});
            running_nxt = 1'b1;
            kick_nxt    = 1'b1;
          end else if (c < $signed({2'b00, SP_START}) && running_r) begin
            c           = 9'sd0;
            running_nxt = 1'b0;
          end
          if (c > $signed({2'b00, SP_MAX})) begin
            c = $signed({2'b00, SP_MAX});
          end
          if (c < 9'sd0) begin
            c = 9'sd0;
          end
          sp_nxt     = c[6:0];
          last_a_nxt = a_r;
        end
      end
      CMD_BUTTON: begin
        if (held_r > long_press_us) begin
          loop_nxt = ~loop_r;
        end else begin
          case (step_r)
            STEP_1:  step_nxt = STEP_2;
            STEP_2:  step_nxt = STEP_5;
            STEP_5:  step_nxt = STEP_10;
            default: step_nxt = STEP_1;
          endcase
        end
      end
      CMD_RPM: begin
        meas_nxt = rpm_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r  <= 1'b0;
      sp_r      <= '0;
      running_r <= 1'b0;
      step_r    <= STEP_1;
      loop_r    <= 1'b0;
      meas_r    <= '0;
      sv_r      <= 1'b0;
    end else if (en) begin
      sv_r <= v1_r;
      if (v1_r) begin
        last_a_r  <= last_a_nxt;
        sp_r      <= sp_nxt;
        running_r <= running_nxt;
        step_r    <= step_nxt;
        loop_r    <= loop_nxt;
        meas_r    <= meas_nxt;
      end
    end
  end

  // The snapshot carries the state after this beat down the duty pipeline.
  always_ff @(posedge clk) begin
    if (en) begin
      snap_r.setpoint <= sp_nxt;
      snap_r.step     <= step_nxt;
      snap_r.loop_on  <= loop_nxt;
      snap_r.measured <= meas_nxt;
      snap_r.kick     <= kick_nxt;
    end
  end

  assign snap_valid = sv_r;
  assign snap       = snap_r;

endmodule

[hdl/fsec_duty.sv]
`timescale 1ns / 1ps

module fsec_duty import fsec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        snap_valid,
  input  snap_t       snap,
  output logic        res_valid,
  output snap_t       res_snap,
  output logic [11:0] res_target,
  output logic [15:0] res_duty
);

  // Stage 3: numerator x with zero and saturation flags.
  logic [18:0]        sp_open;
  logic [18:0]        sp_closed;
  logic signed [19:0] x;
  logic               v3_r;
  snap_t              s3_r;
  logic [17:0]        x3_r;
  logic               zero3_r;
  logic               sat3_r;
  logic [11:0]        tgt3_r;

  assign sp_open   = 19'(snap.setpoint) * OPEN_GAIN;
  assign sp_closed = 19'(snap.setpoint) * CLOSED_GAIN;
  assign x = snap.loop_on ? ($signed({1'b0, sp_closed}) - $signed({6'b0, snap.measured}))
                          : $signed({1'b0, sp_open});

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r    <= snap;
      x3_r    <= x[17:0];
      zero3_r <= (x <= 20'sd0);
      sat3_r  <= (x >= $signed(X_FULL));
      tgt3_r  <= 12'(snap.setpoint) * RPM_PER_PCT;
    end
  end

  // Stage 4: quotient estimate by reciprocal, never above the true quotient
  // and at most one below it.
  logic [48:0] prod;
  logic        v4_r;
  snap_t       s4_r;
  logic [17:0] x4_r;
  logic        zero4_r;
  logic        sat4_r;
  logic [11:0] tgt4_r;
  logic [15:0] qe4_r;

  assign prod = 49'(x3_r) * 49'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r    <= s3_r;
      x4_r    <= x3_r;
      zero4_r <= zero3_r;
      sat4_r  <= sat3_r;
      tgt4_r  <= tgt3_r;
      qe4_r   <= prod[47:32];
    end
  end

  // Output stage: remainder check and final saturation.
  logic [29:0] rem;
  logic [15:0] q;
  logic        vo_r;
  snap_t       so_r;
  logic [11:0] tgto_r;
  logic [15:0] duty_r;

  assign rem = {x4_r, 12'b0} - 30'(qe4_r) * DIV_D;
  assign q   = qe4_r + 16'(rem >= DIV_D);

  always_ff @(posedge clk) begin
    if (en) begin
      so_r   <= s4_r;
      tgto_r <= tgt4_r;
      if (sat4_r) begin
        duty_r <= 16'hFFFF;
      end else if (zero4_r) begin
        duty_r <= '0;
      end else begin
        duty_r <= q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v3_r <= snap_valid;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  assign res_valid  = vo_r;
  assign res_snap   = so_r;
  assign res_target = tgto_r;
  assign res_duty   = duty_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !sat4_r && !zero4_r |-> rem < (DIV_D << 1))
    else $error("duty quotient estimate off by more than one");

endmodule

[hdl/fan_setpoint_encoder_controller.sv]
`timescale 1ns / 1ps

// Fan setpoint controller fed by encoder samples, button releases and rpm
// updates. Each input beat (in_cmd selects its kind) yields exactly one
// result beat showing setpoint, step size, loop mode, target rpm, PWM duty
// and the lamps after that beat; out_kick marks the beat where the fan
// leaves rest.
// Throughput: one beat per cycle unless out_ready holds the pipeline; the
// whole pipeline (input register, state update, numerator, reciprocal
// multiply, remainder correction) advances together.
// When out_ready is low with a result waiting, the pipeline holds and
// in_ready drops; no beat is lost or repeated.
// The register long_press_us sits at byte address 0 of the APB port; write
// it only while no beat is in flight.
// Reset (rst_n low, synchronous) empties the pipeline, clears the setpoint,
// loop mode and measured rpm, sets the step to 1 and long_press_us to
// 2000000 microseconds.

module fan_setpoint_encoder_controller import fsec_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_enc_a,
  input  logic        in_enc_b,
  input  logic [23:0] in_held_us,
  input  logic [13:0] in_rpm_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_setpoint_pct,
  output logic [3:0]  out_step_size,
  output logic        out_closed_loop,
  output logic [11:0] out_target_rpm,
  output logic [15:0] out_duty_q16,
  output logic        out_kick,
  output logic        out_run_led,
  output logic        out_mode_led_red,
  output logic        out_mode_led_green,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [23:0] long_press_r;
  logic        en;
  logic        snap_valid;
  snap_t       snap;
  logic        res_valid;
  snap_t       res_snap;
  logic [11:0] res_target;
  logic [15:0] res_duty;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_LONG_PRESS) begin
      long_press_r <= cfg_pwdata[23:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LONG_PRESS) ? {8'b0, long_press_r} : '0;

  assign en       = !res_valid || out_ready;
  assign in_ready = en;

  fsec_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (in_valid),
    .in_cmd        (in_cmd),
    .in_enc_a      (in_enc_a),
    .in_enc_b      (in_enc_b),
    .in_held_us    (in_held_us),
    .in_rpm_in     (in_rpm_in),
    .long_press_us (long_press_r),
    .snap_valid    (snap_valid),
    .snap          (snap)
  );

  fsec_duty u_duty (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .snap_valid (snap_valid),
    .snap       (snap),
    .res_valid  (res_valid),
    .res_snap   (res_snap),
    .res_target (res_target),
    .res_duty   (res_duty)
  );

  assign out_valid          = res_valid;
  assign out_setpoint_pct   = res_snap.setpoint;
  assign out_step_size      = res_snap.step;
  assign out_closed_loop    = res_snap.loop_on;
  assign out_target_rpm     = res_target;
  assign out_duty_q16       = res_duty;
  assign out_kick           = res_snap.kick;
  assign out_run_led        = (res_snap.setpoint >= SP_START);
  assign out_mode_led_red   = res_snap.loop_on;
  assign out_mode_led_green = ~res_snap.loop_on;

  a_full_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_closed_loop && out_setpoint_pct == SP_MAX |-> out_duty_q16 == 16'hFFFF)
    else $error("open loop full speed does not saturate duty");

  a_kick_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kick |-> out_setpoint_pct == SP_START)
    else $error("kick without start setpoint");

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_setpoint_pct == 7'd0 ||
                   (out_setpoint_pct >= SP_START && out_setpoint_pct <= SP_MAX)))
    else $error("setpoint outside rest or run range");

  a_step_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_step_size == STEP_1 || out_step_size == STEP_2 ||
                   out_step_size == STEP_5 || out_step_size == STEP_10))
    else $error("step size off its cycle");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import fsec_pkg::*;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam logic [2:0] ADDR_LONG_PRESS = 3'd0;
  localparam int         ITEMS_PER_PHASE = 330;
  localparam int         NUM_PHASES      = 5;
  localparam int         DRAIN_CYCLES    = 12;
  localparam int         IDLE_LIMIT      = 4000;
  localparam int         HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        enc_a;
    logic        enc_b;
    logic [23:0] held;
    logic [13:0] rpm;
  } fan_event_t;

  typedef struct packed {
    logic [6:0]  setpoint;
    logic [3:0]  step;
    logic        closed;
    logic [11:0] target;
    logic [15:0] duty;
    logic        kick;
    logic        run;
    logic        red;
    logic        green;
  } fan_status_t;

  typedef struct {
    fan_event_t  ev;
    bit          typed;
    fan_status_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = CMD_ENC;
  logic        in_enc_a = 1'b0;
  logic        in_enc_b = 1'b0;
  logic [23:0] in_held_us = '0;
  logic [13:0] in_rpm_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_setpoint_pct;
  logic [3:0]  out_step_size;
  logic        out_closed_loop;
  logic [11:0] out_target_rpm;
  logic [15:0] out_duty_q16;
  logic        out_kick;
  logic        out_run_led;
  logic        out_mode_led_red;
  logic        out_mode_led_green;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Side information that travels with the beat on the input channel.
  logic        cur_typed = 1'b0;
  fan_status_t cur_want = '0;

  // Shadow of the block's state and its register.
  logic        fan_last_a = 1'b0;
  int          fan_setpoint = 0;
  logic        fan_running = 1'b0;
  logic [3:0]  fan_step = STEP_1;
  logic        fan_loop = 1'b0;
  logic [13:0] fan_measured = '0;
  logic [23:0] fan_long_press = LONG_PRESS_RST;

  fan_status_t   expected_status[$];
  directed_row_t directed_rows[$];
  fan_status_t   predicted;

  logic gen_a = 1'b0;
  logic drift_up = 1'b1;

  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int kicks_seen = 0;
  int idle_cycles = 0;

  fan_setpoint_encoder_controller dut (.*);

  always #5 clk = ~clk;

  // Applies one event to the shadow state and returns the status it shows.
  function automatic fan_status_t advance_fan(input fan_event_t ev);
    int          c;
    longint      tgt;
    longint      num;
    longint      q;
    logic        kicked;
    fan_status_t r;
    kicked = 1'b0;
    case (ev.cmd)
      CMD_ENC: begin
        if (ev.enc_a != fan_last_a) begin
          if (ev.enc_b != ev.enc_a) c = fan_setpoint + int'(fan_step);
          else c = fan_setpoint - int'(fan_step);
          if (c > 0 && !fan_running) begin
            c = SP_START;
            fan_running = 1'b1;
            kicked = 1'b1;
          end
          // Compare as signed so a step below zero clamps to rest, not full speed.
          if (c < int'(SP_START) && fan_running) begin
            c = 0;
            fan_running = 1'b0;
          end
          if (c > int'(SP_MAX)) c = SP_MAX;
          if (c < 0) c = 0;
          fan_setpoint = c;
          fan_last_a = ev.enc_a;
        end
      end
      CMD_BUTTON: begin
        if (ev.held > fan_long_press) begin
          fan_loop = ~fan_loop;
        end else begin
          case (fan_step)
            STEP_1:  fan_step = STEP_2;
            STEP_2:  fan_step = STEP_5;
            STEP_5:  fan_step = STEP_10;
            default: fan_step = STEP_1;
          endcase
        end
      end
      CMD_RPM: fan_measured = ev.rpm;
      default: ;
    endcase
    tgt = longint'(fan_setpoint) * 21;
    if (fan_loop) begin
      num = 65536 * (101 * tgt - longint'(fan_measured));
      q = (num <= 0) ? 0 : num / 210000;
    end else begin
      q = (longint'(fan_setpoint) * 65536) / 100;
    end
    if (q > 65535) q = 65535;
    r.setpoint = 7'(fan_setpoint);
    r.step     = fan_step;
    r.closed   = fan_loop;
    r.target   = 12'(tgt);
    r.duty     = 16'(q);
    r.kick     = kicked;
    r.run      = (fan_setpoint >= int'(SP_START));
    r.red      = fan_loop;
    r.green    = ~fan_loop;
    return r;
  endfunction

  // Mostly clean quadrature motion with a slowly changing direction, plus
  // button releases around the threshold, rpm updates and the unused code.
  function automatic fan_event_t random_event();
    fan_event_t ev;
    int         r;
    ev.enc_a = 1'($urandom);
    ev.enc_b = 1'($urandom);
    ev.held  = 24'($urandom);
    ev.rpm   = 14'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) begin
      ev.cmd = CMD_ENC;
      if ($urandom_range(0, 99) < 85) gen_a = ~gen_a;
      ev.enc_a = gen_a;
      if ($urandom_range(0, 99) < 85) ev.enc_b = drift_up ? ~gen_a : gen_a;
      if ($urandom_range(0, 29) == 0) drift_up = ~drift_up;
    end else if (r < 82) begin
      ev.cmd = CMD_BUTTON;
      case ($urandom_range(0, 5))
        0: ev.held = '0;
        1: ev.held = fan_long_press;
        2: ev.held = (fan_long_press == '1) ? fan_long_press : fan_long_press + 24'd1;
        3: ev.held = '1;
        4: ev.held = fan_long_press + 24'($urandom_range(0, 64)) - 24'd32;
        default: ;
      endcase
    end else if (r < 95) begin
      ev.cmd = CMD_RPM;
      case ($urandom_range(0, 3))
        0: ev.rpm = '0;
        1: ev.rpm = '1;
        2: ev.rpm = 14'(fan_setpoint * 21 + int'($urandom_range(0, 400)) - 200);
        default: ;
      endcase
    end else begin
      ev.cmd = CMD_UNUSED;
    end
    return ev;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic a, input logic b,
                         input logic [23:0] held, input logic [13:0] rpm,
                         input bit typed, input fan_status_t want);
    directed_row_t row;
    row.ev    = '{cmd, a, b, held, rpm};
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Entered and left right after a rising edge; valid stays high between
  // back-to-back beats.
  task automatic send_event(input fan_event_t ev, input bit typed, input fan_status_t want,
                            input bit steady);
    int gap;
    int r;
    gap = 0;
    if (!steady) begin
      r = $urandom_range(0, 99);
      if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= ev.cmd;
    in_enc_a   <= ev.enc_a;
    in_enc_b   <= ev.enc_b;
    in_held_us <= ev.held;
    in_rpm_in  <= ev.rpm;
    cur_typed  <= typed;
    cur_want   <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_long_press(input logic [23:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_LONG_PRESS;
    cfg_pwdata  <= {8'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    fan_long_press = value;
    // Read the register back.
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[23:0] !== value) begin
      $error("long_press_us readback: expected %0d, got %0d", value, cfg_prdata[23:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predicted = advance_fan('{in_cmd, in_enc_a, in_enc_b, in_held_us, in_rpm_in});
      expected_status.push_back(cur_typed ? cur_want : predicted);
    end
  end

  always @(posedge clk) begin
    fan_status_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_kick === 1'b1) kicks_seen++;
      if (expected_status.size() == 0) begin
        $error("result beat arrived with no expectation waiting");
        errors++;
      end else begin
        want = expected_status.pop_front();
        compare_field("setpoint_pct", want.setpoint, out_setpoint_pct);
        compare_field("step_size", want.step, out_step_size);
        compare_field("closed_loop", want.closed, out_closed_loop);
        compare_field("target_rpm", want.target, out_target_rpm);
        compare_field("duty_q16", want.duty, out_duty_q16);
        compare_field("kick", want.kick, out_kick);
        compare_field("run_led", want.run, out_run_led);
        compare_field("mode_led_red", want.red, out_mode_led_red);
        compare_field("mode_led_green", want.green, out_mode_led_green);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold-off that backs the block up,
  // and a window of results taken without any stall.
  initial begin
    int  n;
    int  r;
    bit  held_off;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!held_off && results_seen >= 500) begin
        held_off = 1'b1;
        n = HOLD_OFF_CYCLES;
      end else if (results_seen % 400 >= 200 && results_seen % 400 < 260) begin
        n = 0;
      end else if (r < 55) begin
        n = 0;
      end else if (r < 90) begin
        n = $urandom_range(1, 3);
      end else if (r < 97) begin
        n = $urandom_range(4, 10);
      end else begin
        n = $urandom_range(20, 50);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    fan_status_t rest;
    fan_status_t fresh_kick;
    fan_status_t full_open;
    logic [23:0] press_settings[NUM_PHASES];
    int          directed_count;
    rest       = '{7'd0, STEP_1, 1'b0, 12'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1};
    fresh_kick = '{7'd15, STEP_1, 1'b0, 12'd315, 16'd9830, 1'b1, 1'b1, 1'b0, 1'b1};
    full_open  = '{7'd100, STEP_10, 1'b0, 12'd2100, 16'd65535, 1'b0, 1'b1, 1'b0, 1'b1};
    press_settings[0] = '0;
    press_settings[1] = '1;
    press_settings[2] = LONG_PRESS_RST;
    press_settings[3] = 24'($urandom);
    press_settings[4] = 24'd1000;

    // A sample with no change of A, a start from rest with kick, and the
    // drop back to rest.
    add_row(CMD_ENC, 1'b0, 1'b0, '0, '0, 1'b1, rest);
    add_row(CMD_ENC, 1'b1, 1'b0, '0, '0, 1'b1, fresh_kick);
    add_row(CMD_ENC, 1'b0, 1'b0, '1, '1, 1'b1, rest);
    // Releases at and just past the threshold, and at the extremes.
    add_row(CMD_BUTTON, 1'b1, 1'b1, 24'd0, '0, 1'b0, rest);
    add_row(CMD_BUTTON, 1'b0, 1'b0, LONG_PRESS_RST, '0, 1'b0, rest);
    add_row(CMD_BUTTON, 1'b0, 1'b0, LONG_PRESS_RST + 24'd1, '0, 1'b0, rest);
    add_row(CMD_BUTTON, 1'b0, 1'b0, '1, '0, 1'b0, rest);
    add_row(CMD_BUTTON, 1'b0, 1'b0, 24'd0, '1, 1'b0, rest);
    // Climb at step 10 until the setpoint clamps at full speed.
    for (int k = 0; k < 11; k++) begin
      add_row(CMD_ENC, ~k[0], k[0], '0, '0, 1'b0, rest);
    end
    add_row(CMD_ENC, 1'b0, 1'b1, '0, '0, 1'b1, full_open);
    add_row(CMD_UNUSED, 1'b1, 1'b1, '1, '1, 1'b1, full_open);
    add_row(CMD_RPM, 1'b0, 1'b0, '0, '1, 1'b0, rest);
    add_row(CMD_BUTTON, 1'b0, 1'b0, '1, '0, 1'b0, rest);
    add_row(CMD_RPM, 1'b0, 1'b0, '0, '0, 1'b0, rest);
    add_row(CMD_ENC, 1'b1, 1'b1, '0, '0, 1'b0, rest);
    add_row(CMD_BUTTON, 1'b0, 1'b0, 24'd0, '0, 1'b0, rest);
    add_row(CMD_ENC, 1'b1, 1'b0, '0, '0, 1'b0, rest);
    gen_a = 1'b1;
    directed_count = directed_rows.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_event(directed_rows[k].ev, directed_rows[k].typed, directed_rows[k].want,
                 1'b0);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_long_press(press_settings[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_event(random_event(), 1'b0, rest, i >= 100 && i < 160);
      end
    end
    drain();

    if (expected_status.size() != 0) begin
      $error("%0d expected results never arrived", expected_status.size());
      errors++;
    end
    $display("Sent %0d beats (%0d directed) under %0d long-press thresholds,",
             beats_sent, directed_count, NUM_PHASES);
    $display("checked %0d result beats, %0d of them starting the fan with a kick.",
             results_seen, kicks_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
